### src/ilid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_pkg
// Types and constants shared by the indexed list core, its cells and its
// channel interfaces.
// ----------------------------------------------------------------------------
package ilid_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned PosW    = 6;
  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 7;

  // Taps ORed together in one register of the read tree.
  localparam int unsigned GroupSize = 8;

  typedef enum logic [OpW-1:0] {
    OP_APPEND    = 3'd0,
    OP_READ      = 3'd1,
    OP_POP       = 3'd2,
    OP_REMOVE_AT = 3'd3,
    OP_INSERT_AT = 3'd4,
    OP_OVERWRITE = 3'd5,
    OP_CLEAR     = 3'd6
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // What every cell of the row does in the cycle an operation is applied.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_WRITE,
    CELL_READ
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [PosW-1:0]   pos;
    logic [DataW-1:0]  value;
  } cell_cmd_t;

endpackage

### src/ilid_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_in_if / ilid_out_if
// Valid/ready channels of the indexed list core: operation words in, result
// words out.
// ----------------------------------------------------------------------------
interface ilid_in_if import ilid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OpW-1:0]           opcode;
  logic [PosW-1:0]          position;
  logic signed [DataW-1:0]  value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface ilid_out_if import ilid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DataW-1:0]  read_value;
  logic [StatusW-1:0]       status;
  logic [CountW-1:0]        count;

  modport source (output valid, output read_value, output status, output count, input ready);
  modport sink   (input valid, input read_value, input status, input count, output ready);
endinterface

### src/indexed_list_insert_delete_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_core
// Ordered list of signed 32-bit values in a row of cells with an element
// count; append, read, remove last, remove at, insert at, overwrite, clear.
//
//   channel  dir  handshake     word
//   in_i     in   valid/ready   opcode, position, value
//   out_o    out  valid/ready   read_value, status, count
//
// A word is taken when no earlier word is still in flight. The cells apply
// the operation at the accept edge, all shifting at once; the read tap and
// the read tree add two register stages and the output register follows, and
// the next word can be taken when that result is taken, so words do not
// overlap in the core. A stalled result holds the input off.
// Reset clears the count and the pipeline valids; entries are not cleared.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_core import ilid_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ilid_in_if.sink     in_i,
  ilid_out_if.source  out_o
);

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW  = (CntW > PosW) ? CntW : PosW;
  // The position field reaches only the low entries.
  localparam int unsigned ReadN = (CAPACITY < (1 << PosW)) ? CAPACITY : (1 << PosW);

  logic [CntW-1:0]    count_q, count_d;
  logic               s1_valid_q, s2_valid_q, out_valid_q;
  logic [StatusW-1:0] s1_status_q, s2_status_q, out_status_q;
  logic [CntW-1:0]    s1_count_q, s2_count_q, out_count_q;
  logic [DataW-1:0]   out_value_q;

  logic               accept;
  cell_cmd_t          cmd;
  status_e            status;
  logic [CmpW-1:0]    pos_w, cnt_w;
  logic               pos_below, pos_upto, full;

  logic [DataW-1:0]   cell_data [CAPACITY];
  logic [DataW-1:0]   taps [ReadN];
  logic [DataW-1:0]   read_word;

  assign in_i.ready = !s1_valid_q && !s2_valid_q && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  assign pos_w     = CmpW'(in_i.position);
  assign cnt_w     = CmpW'(count_q);
  assign pos_below = pos_w < cnt_w;
  assign pos_upto  = pos_w <= cnt_w;
  assign full      = count_q == CntW'(CAPACITY);

  always_comb begin
    cmd.op    = CELL_HOLD;
    cmd.pos   = in_i.position;
    cmd.value = in_i.value;
    status    = ST_OK;
    count_d   = count_q;
    unique case (in_i.opcode)
      OP_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.op  = CELL_APPEND;
          count_d = count_q + CntW'(1);
        end
      end
      OP_READ: begin
        if (!pos_below) status = ST_RANGE;
        else            cmd.op = CELL_READ;
      end
      OP_POP: begin
        if (count_q != '0) count_d = count_q - CntW'(1);
      end
      OP_REMOVE_AT: begin
        if (!pos_below) begin
          status = ST_RANGE;
        end else begin
          cmd.op  = CELL_REMOVE;
          count_d = count_q - CntW'(1);
        end
      end
      OP_INSERT_AT: begin
        // The index check comes before the full check.
        if (!pos_upto) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          cmd.op  = CELL_INSERT;
          count_d = count_q + CntW'(1);
        end
      end
      OP_OVERWRITE: begin
        if (!pos_below) status = ST_RANGE;
        else            cmd.op = CELL_WRITE;
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    if (!accept) begin
      cmd.op  = CELL_HOLD;
      count_d = count_q;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DataW-1:0] left, right, tap;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_right
      assign right = cell_data[i+1];
    end

    ilid_cell #(
      .Capacity (CAPACITY),
      .Index    (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .count_i (count_q),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .tap_o   (tap)
    );

    if (i < ReadN) begin : g_tap
      assign taps[i] = tap;
    end
  end

  ilid_read_tree #(
    .NumTaps (ReadN)
  ) u_read_tree (
    .clk_i  (clk_i),
    .taps_i (taps),
    .word_o (read_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      if (s2_valid_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= status;
      s1_count_q  <= count_d;
    end
    s2_status_q <= s1_status_q;
    s2_count_q  <= s1_count_q;
    if (s2_valid_q) begin
      out_status_q <= s2_status_q;
      out_count_q  <= s2_count_q;
      out_value_q  <= read_word;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = $signed(out_value_q);
  assign out_o.status     = out_status_q;
  assign out_o.count      = CountW'(out_count_q);

endmodule

### src/ilid_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_cell
// One list entry. Loads the new value, takes its left or right neighbor's
// entry for a shift, or holds; presents its entry on the read tap when
// addressed by a read.
// ----------------------------------------------------------------------------
module ilid_cell import ilid_pkg::*; #(
  parameter int unsigned Capacity = 64,
  parameter int unsigned Index    = 0,
  localparam int unsigned CntW    = $clog2(Capacity + 1),
  localparam int unsigned CmpW    = (CntW > PosW) ? CntW : PosW
) (
  input  logic              clk_i,
  input  cell_cmd_t         cmd_i,
  input  logic [CntW-1:0]   count_i,
  input  logic [DataW-1:0]  left_i,
  input  logic [DataW-1:0]  right_i,
  output logic [DataW-1:0]  data_o,
  output logic [DataW-1:0]  tap_o
);

  logic [DataW-1:0] data_q, data_d;
  logic [DataW-1:0] tap_q, tap_d;
  logic [CmpW-1:0]  idx, pos, cnt;

  assign idx = CmpW'(Index);
  assign pos = CmpW'(cmd_i.pos);
  assign cnt = CmpW'(count_i);

  always_comb begin
    data_d = data_q;
    tap_d  = '0;
    unique case (cmd_i.op)
      CELL_APPEND: begin
        if (idx == cnt) data_d = cmd_i.value;
      end
      CELL_INSERT: begin
        if (idx == pos) begin
          data_d = cmd_i.value;
        end else if (idx > pos) begin
          data_d = left_i;
        end
      end
      CELL_REMOVE: begin
        if (idx >= pos) data_d = right_i;
      end
      CELL_WRITE: begin
        if (idx == pos) data_d = cmd_i.value;
      end
      CELL_READ: begin
        if (idx == pos) tap_d = data_q;
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    tap_q  <= tap_d;
  end

  assign data_o = data_q;
  assign tap_o  = tap_q;

endmodule

### src/ilid_read_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_read_tree
// Registered OR tree over the cells' read taps. At most one tap is nonzero,
// so the OR of all taps is the addressed entry.
// ----------------------------------------------------------------------------
module ilid_read_tree import ilid_pkg::*; #(
  parameter int unsigned NumTaps    = 64,
  localparam int unsigned NumGroups = (NumTaps + GroupSize - 1) / GroupSize
) (
  input  logic              clk_i,
  input  logic [DataW-1:0]  taps_i [NumTaps],
  output logic [DataW-1:0]  word_o
);

  logic [DataW-1:0] member [NumGroups][GroupSize];
  logic [DataW-1:0] group_d [NumGroups];
  logic [DataW-1:0] group_q [NumGroups];

  for (genvar g = 0; g < NumGroups; g++) begin : g_group
    for (genvar k = 0; k < GroupSize; k++) begin : g_member
      if (g * GroupSize + k < NumTaps) begin : g_tap
        assign member[g][k] = taps_i[g * GroupSize + k];
      end else begin : g_pad
        assign member[g][k] = '0;
      end
    end

    always_comb begin
      group_d[g] = '0;
      for (int k = 0; k < GroupSize; k++) begin
        group_d[g] = group_d[g] | member[g][k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    group_q <= group_d;
  end

  always_comb begin
    word_o = '0;
    for (int g = 0; g < NumGroups; g++) begin
      word_o = word_o | group_q[g];
    end
  end

endmodule

### tb/indexed_list_insert_delete_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_core_test
// Runs a short table of list operations through the core. Rows whose
// results are plain edge cases carry them typed in, and the other rows are
// checked against a behavioral list kept in this module. Random operation
// words follow, biased to fill the list to capacity and drain it again. The
// receiver and the sender stall at random in two phases; a third has none.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_core_test;
  import ilid_pkg::*;

  localparam int unsigned Capacity    = 64;
  localparam int unsigned IdxW        = $clog2(Capacity);
  localparam int unsigned PhaseWords  = 550;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned MaxPrinted  = 100;

  // The one opcode with no operation behind it; the core leaves the list alone.
  localparam logic [OpW-1:0] OpUnused = 3'd7;

  typedef struct packed {
    logic [OpW-1:0]          opcode;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] value;
  } op_word_t;

  typedef struct packed {
    logic signed [DataW-1:0] read_value;
    logic [StatusW-1:0]      status;
    logic [CountW-1:0]       count;
  } list_result_t;

  typedef struct packed {
    op_word_t     word;
    logic         known;
    list_result_t result;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  ilid_in_if  in_ch ();
  ilid_out_if out_ch ();

  indexed_list_insert_delete_core #(
    .CAPACITY(Capacity)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Behavioral copy of the list.
  logic signed [DataW-1:0] list_mem [Capacity];
  int unsigned             list_len = 0;
  bit                      growing  = 1'b1;

  list_result_t results_due [$];
  stim_row_t    directed_rows [$];
  int unsigned  mismatches   = 0;
  int unsigned  idle_cycles  = 0;
  int unsigned  src_idle_pct = 0;
  int unsigned  rcv_idle_pct = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic list_result_t apply_list_op(input op_word_t w);
    list_result_t r;
    int unsigned  p;
    int unsigned  i;
    r = '0;
    r.status = ST_OK;
    p = 32'(w.position);
    case (w.opcode)
      OP_APPEND: begin
        if (list_len >= Capacity) begin
          r.status = ST_FULL;
        end else begin
          list_mem[IdxW'(list_len)] = w.value;
          list_len++;
        end
      end
      OP_READ: begin
        if (p >= list_len) r.status = ST_RANGE;
        else r.read_value = list_mem[IdxW'(p)];
      end
      OP_POP: begin
        if (list_len > 0) list_len--;
      end
      OP_REMOVE_AT: begin
        if (p >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = p; i + 1 < list_len; i++) list_mem[IdxW'(i)] = list_mem[IdxW'(i + 1)];
          list_len--;
        end
      end
      OP_INSERT_AT: begin
        // The index is checked before the fill level.
        if (p > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= Capacity) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i > p; i--) list_mem[IdxW'(i)] = list_mem[IdxW'(i - 1)];
          list_mem[IdxW'(p)] = w.value;
          list_len++;
        end
      end
      OP_OVERWRITE: begin
        if (p >= list_len) r.status = ST_RANGE;
        else list_mem[IdxW'(p)] = w.value;
      end
      OP_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    r.count = list_len[CountW-1:0];
    return r;
  endfunction

  function automatic stim_row_t checked_row(input logic [OpW-1:0] op,
                                            input logic [PosW-1:0] pos,
                                            input logic signed [DataW-1:0] val);
    stim_row_t row;
    row = '0;
    row.word = '{opcode: op, position: pos, value: val};
    return row;
  endfunction

  function automatic stim_row_t known_row(input logic [OpW-1:0] op,
                                          input logic [PosW-1:0] pos,
                                          input logic signed [DataW-1:0] val,
                                          input logic signed [DataW-1:0] rd,
                                          input logic [StatusW-1:0] st,
                                          input logic [CountW-1:0] cnt);
    stim_row_t row;
    row = checked_row(op, pos, val);
    row.known = 1'b1;
    row.result = '{read_value: rd, status: st, count: cnt};
    return row;
  endfunction

  function automatic op_word_t random_word();
    op_word_t    w;
    int unsigned r;
    int unsigned span;
    r = $urandom_range(99);
    if (r < 1) begin
      w.opcode = OpUnused;
    end else if (!growing && r < 4) begin
      w.opcode = OP_CLEAR;
    end else if (growing) begin
      if (r < 35) w.opcode = OP_APPEND;
      else if (r < 55) w.opcode = OP_INSERT_AT;
      else if (r < 72) w.opcode = OP_READ;
      else if (r < 84) w.opcode = OP_OVERWRITE;
      else if (r < 92) w.opcode = OP_REMOVE_AT;
      else w.opcode = OP_POP;
    end else begin
      if (r < 30) w.opcode = OP_POP;
      else if (r < 56) w.opcode = OP_REMOVE_AT;
      else if (r < 72) w.opcode = OP_READ;
      else if (r < 84) w.opcode = OP_OVERWRITE;
      else if (r < 92) w.opcode = OP_APPEND;
      else w.opcode = OP_INSERT_AT;
    end

    // Mostly valid positions, with both ends favored; the rest is noise.
    span = (w.opcode == OP_INSERT_AT) ? list_len : list_len - 1;
    if (span > Capacity - 1) span = Capacity - 1;
    r = $urandom_range(99);
    if (r < 12 || (list_len == 0 && w.opcode != OP_INSERT_AT)) begin
      w.position = PosW'($urandom_range(Capacity - 1));
    end else if (r < 22) begin
      w.position = '0;
    end else if (r < 32) begin
      w.position = span[PosW-1:0];
    end else begin
      w.position = PosW'($urandom_range(span));
    end

    r = $urandom_range(99);
    case (r % 4)
      0: w.value = 32'sh8000_0000;
      1: w.value = 32'sh7fff_ffff;
      2: w.value = '0;
      default: w.value = -32'sd1;
    endcase
    if (r >= 10) w.value = $urandom;
    return w;
  endfunction

  task automatic send_word(input op_word_t w, input logic known,
                           input list_result_t known_result);
    list_result_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= w.opcode;
    in_ch.position <= w.position;
    in_ch.value    <= w.value;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    predicted = apply_list_op(w);
    results_due.push_back(known ? known_result : predicted);
  endtask

  // Drops valid and lets every outstanding result come back.
  task automatic hold_off();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned words);
    repeat (words) begin
      if (list_len == 0) growing = 1'b1;
      else if (list_len >= Capacity && $urandom_range(3) == 0) growing = 1'b0;
      else if ($urandom_range(199) == 0) growing = !growing;
      send_word(random_word(), 1'b0, '0);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    end
  endtask

  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result, count", DataW'(out_ch.count), '0);
      end else begin
        want = results_due.pop_front();
        if (out_ch.read_value !== want.read_value)
          report_mismatch("read_value", out_ch.read_value, want.read_value);
        if (out_ch.status !== want.status)
          report_mismatch("status", DataW'(out_ch.status), DataW'(want.status));
        if (out_ch.count !== want.count)
          report_mismatch("count", DataW'(out_ch.count), DataW'(want.count));
      end
    end
  end

  // Ends the run when no word moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Timeout: no word moved for %0d cycles", StallLimit);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = '0;
    in_ch.position = '0;
    in_ch.value    = '0;

    // Edge cases on an empty and a short list, then shifts in the middle.
    directed_rows.push_back(known_row(OP_READ, 6'd0, 32'sd0, 32'sd0, ST_RANGE, 7'd0));
    directed_rows.push_back(known_row(OP_POP, 6'd0, 32'sd0, 32'sd0, ST_OK, 7'd0));
    directed_rows.push_back(known_row(OP_REMOVE_AT, 6'd0, 32'sd0, 32'sd0, ST_RANGE, 7'd0));
    directed_rows.push_back(known_row(OP_OVERWRITE, 6'd0, 32'sd1, 32'sd0, ST_RANGE, 7'd0));
    directed_rows.push_back(known_row(OP_INSERT_AT, 6'd1, 32'sd1, 32'sd0, ST_RANGE, 7'd0));
    directed_rows.push_back(known_row(OP_INSERT_AT, 6'd0, 32'sh8000_0000,
                                      32'sd0, ST_OK, 7'd1));
    directed_rows.push_back(known_row(OP_APPEND, 6'd63, 32'sh7fff_ffff,
                                      32'sd0, ST_OK, 7'd2));
    directed_rows.push_back(known_row(OP_READ, 6'd0, 32'sd0, 32'sh8000_0000, ST_OK, 7'd2));
    directed_rows.push_back(known_row(OP_READ, 6'd1, 32'sd0, 32'sh7fff_ffff, ST_OK, 7'd2));
    directed_rows.push_back(known_row(OP_READ, 6'd63, 32'sd0, 32'sd0, ST_RANGE, 7'd2));
    directed_rows.push_back(known_row(OP_INSERT_AT, 6'd63, 32'sd3, 32'sd0, ST_RANGE, 7'd2));
    directed_rows.push_back(known_row(OpUnused, 6'd63, -32'sd1, 32'sd0, ST_OK, 7'd2));
    directed_rows.push_back(known_row(OP_OVERWRITE, 6'd1, -32'sd1, 32'sd0, ST_OK, 7'd2));
    directed_rows.push_back(checked_row(OP_INSERT_AT, 6'd1, 32'sd5));
    directed_rows.push_back(checked_row(OP_INSERT_AT, 6'd3, 32'sh1234_5678));
    directed_rows.push_back(checked_row(OP_READ, 6'd1, 32'sd0));
    directed_rows.push_back(checked_row(OP_READ, 6'd2, 32'sd0));
    directed_rows.push_back(checked_row(OP_READ, 6'd3, 32'sd0));
    directed_rows.push_back(checked_row(OP_REMOVE_AT, 6'd0, 32'sd0));
    directed_rows.push_back(known_row(OP_REMOVE_AT, 6'd3, 32'sd0, 32'sd0, ST_RANGE, 7'd3));
    directed_rows.push_back(checked_row(OP_POP, 6'd0, 32'sd0));
    directed_rows.push_back(checked_row(OP_READ, 6'd1, 32'sd0));
    directed_rows.push_back(known_row(OP_OVERWRITE, 6'd2, 32'sd7, 32'sd0, ST_RANGE, 7'd2));
    directed_rows.push_back(known_row(OP_CLEAR, 6'd0, 32'sd0, 32'sd0, ST_OK, 7'd0));
    directed_rows.push_back(known_row(OP_READ, 6'd0, 32'sd0, 32'sd0, ST_RANGE, 7'd0));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct = 17;
    rcv_idle_pct = 72;
    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].result);
    end
    send_random(PhaseWords);
    hold_off();

    src_idle_pct = 72;
    rcv_idle_pct = 17;
    send_random(PhaseWords);
    hold_off();

    src_idle_pct = 0;
    rcv_idle_pct = 0;
    send_random(PhaseWords);
    hold_off();

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
